@@ rtl/fagc_pkg.sv @@
// ----------------------------------------------------------------------------
// fagc_pkg - shared types and constants of the FIR filter with gain control
// Sequencer states, control structs between sequencer and MAC datapath,
// register indexes, fixed field widths and saturation helpers.
// ----------------------------------------------------------------------------
package fagc_pkg;

	// fixed field widths
	localparam int SAMPLE_W    = 16;
	localparam int COEF_W      = 16;
	localparam int COEF_IDX_W  = 6;
	localparam int GAIN_W      = 12;
	localparam int THR_W       = 15;
	localparam int PEAK_W      = 15;
	localparam int HIST_W      = PEAK_W - 4;
	localparam int PROD_W      = 32;
	localparam int CFG_INDEX_W = 2;

	// opcodes of an input transfer
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_COEF   = 1'b1;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_WEAK_THRESHOLD = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_HIGH_THRESHOLD = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_LOW_THRESHOLD  = 2'd2;

	// register reset values, Q2.14
	localparam logic [THR_W-1:0] WEAK_THRESHOLD_RST = 15'd1638;
	localparam logic [THR_W-1:0] HIGH_THRESHOLD_RST = 15'd13107;
	localparam logic [THR_W-1:0] LOW_THRESHOLD_RST  = 15'd9830;

	// gain in Q2.10
	localparam logic signed [GAIN_W-1:0] GAIN_ONE  = 12'sd1024;
	localparam logic signed [GAIN_W-1:0] GAIN_MAX  = 12'sd2047;
	localparam logic signed [GAIN_W-1:0] GAIN_MIN  = -12'sd2048;
	localparam logic signed [GAIN_W:0]   GAIN_STEP = 13'sd2;

	localparam logic signed [SAMPLE_W-1:0] OUT_MAX = 16'sh7fff;
	localparam logic signed [SAMPLE_W-1:0] OUT_MIN = -16'sh8000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_SCALE,
		ST_FINISH,
		ST_PUSH,
		ST_ADJUST
	} fagc_state_t;

	// sequencer commands to the MAC datapath
	typedef struct packed {
		logic shift_in;
		logic clear;
		logic step;
		logic scale;
	} mac_ctrl_t;

	// MAC datapath status
	typedef struct packed {
		logic busy;
	} mac_stat_t;

	// Q8.24 gain product to Q2.14: floor shift by 10 and saturate
	function automatic logic signed [SAMPLE_W-1:0] sat_scaled(
		input logic signed [PROD_W-1:0] p);
		logic same;
		same = (&p[PROD_W-1:25]) | ~(|p[PROD_W-1:25]);
		if (same)
			return p[25:10];
		else if (p[PROD_W-1])
			return OUT_MIN;
		else
			return OUT_MAX;
	endfunction

	// absolute value, most negative code clamps to full scale
	function automatic logic [PEAK_W-1:0] abs_sat(input logic signed [SAMPLE_W-1:0] y);
		logic signed [SAMPLE_W-1:0] neg;
		neg = -y;
		if (!y[SAMPLE_W-1])
			return y[PEAK_W-1:0];
		else if (y == OUT_MIN)
			return {PEAK_W{1'b1}};
		else
			return neg[PEAK_W-1:0];
	endfunction

endpackage

@@ rtl/fagc_if.sv @@
// ----------------------------------------------------------------------------
// fagc_if - valid/ready channels of the FIR filter with gain control
// Input channel carries a sample or a coefficient write; output channel
// carries the scaled filter output and the gain that produced it.
// ----------------------------------------------------------------------------
interface fagc_in_if;
	import fagc_pkg::*;

	logic                           valid;
	logic                           ready;
	logic                           opcode;
	logic signed [SAMPLE_W-1:0]     sample_in;
	logic        [COEF_IDX_W-1:0]   coef_index;
	logic signed [COEF_W-1:0]       coef_value;

	modport source (output valid, opcode, sample_in, coef_index, coef_value, input ready);
	modport sink   (input valid, opcode, sample_in, coef_index, coef_value, output ready);
endinterface

interface fagc_out_if;
	import fagc_pkg::*;

	logic                         valid;
	logic                         ready;
	logic signed [SAMPLE_W-1:0]   filtered_out;
	logic signed [GAIN_W-1:0]     gain_now;

	modport source (output valid, filtered_out, gain_now, input ready);
	modport sink   (input valid, filtered_out, gain_now, output ready);
endinterface

@@ rtl/fagc_mac.sv @@
// ----------------------------------------------------------------------------
// fagc_mac - shared multiply-accumulate datapath
// Holds the rotating delay line and the coefficient memory, and one 16x16
// multiplier that serves both the tap products and the gain scaling.
// ----------------------------------------------------------------------------
module fagc_mac #(
	parameter int TAPS = 32
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  fagc_pkg::mac_ctrl_t                    ctrl,
	input  logic [(TAPS > 1 ? $clog2(TAPS) : 1)-1:0] tap_idx,
	input  logic signed [fagc_pkg::SAMPLE_W-1:0]   sample,
	input  logic                                   coef_we,
	input  logic [(TAPS > 1 ? $clog2(TAPS) : 1)-1:0] coef_addr,
	input  logic signed [fagc_pkg::COEF_W-1:0]     coef_data,
	input  logic signed [fagc_pkg::SAMPLE_W-1:0]   filt,
	input  logic signed [fagc_pkg::GAIN_W-1:0]     gain,
	output logic signed [32+$clog2(TAPS)-1:0]      acc,
	output logic signed [fagc_pkg::PROD_W-1:0]     prod,
	output fagc_pkg::mac_stat_t                    stat
);
	import fagc_pkg::*;

	localparam int ACC_W = 32 + $clog2(TAPS);

	logic signed [SAMPLE_W-1:0] dly_q  [TAPS];
	logic signed [SAMPLE_W-1:0] dly_d  [TAPS];
	logic signed [COEF_W-1:0]   coef_mem [TAPS];
	logic signed [COEF_W-1:0]   coef_rd_q;
	logic signed [SAMPLE_W-1:0] tap_s1;
	logic                       v_s1;
	logic                       v_s2;
	logic signed [SAMPLE_W-1:0] mul_a;
	logic signed [SAMPLE_W-1:0] mul_b;
	logic signed [PROD_W-1:0]   prod_s2;
	logic signed [ACC_W-1:0]    acc_q;

	// shift in a new sample, or rotate so tap k sits at the head on step k
	always_comb begin
		dly_d = dly_q;
		if (ctrl.shift_in) begin
			for (int i = TAPS - 1; i > 0; i--)
				dly_d[i] = dly_q[i-1];
			dly_d[0] = sample;
		end else if (ctrl.step) begin
			for (int i = 0; i < TAPS - 1; i++)
				dly_d[i] = dly_q[i+1];
			dly_d[TAPS-1] = dly_q[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAPS; i++)
				dly_q[i] <= '0;
		end else begin
			dly_q <= dly_d;
		end
	end

	// coefficient memory, registered read
	always_ff @(posedge clk) begin
		if (coef_we)
			coef_mem[coef_addr] <= coef_data;
		coef_rd_q <= coef_mem[tap_idx];
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= ctrl.step;
			v_s2 <= v_s1;
		end
	end

	// operand select: tap product or gain scaling
	always_comb begin
		if (ctrl.scale) begin
			mul_a = filt;
			mul_b = {{(SAMPLE_W-GAIN_W){gain[GAIN_W-1]}}, gain};
		end else begin
			mul_a = tap_s1;
			mul_b = coef_rd_q;
		end
	end

	// hold the tap, multiply, accumulate
	always_ff @(posedge clk) begin
		if (ctrl.step)
			tap_s1 <= dly_q[0];
		if (ctrl.scale || v_s1)
			prod_s2 <= mul_a * mul_b;
		if (ctrl.clear)
			acc_q <= '0;
		else if (v_s2)
			acc_q <= acc_q + ACC_W'(prod_s2);
	end

	assign acc       = acc_q;
	assign prod      = prod_s2;
	assign stat.busy = v_s1 | v_s2;

endmodule

@@ rtl/fir_filter_with_agc_unit.sv @@
// ----------------------------------------------------------------------------
// fir_filter_with_agc_unit - FIR filter with automatic gain control
// Sequencer, gain control loop and output register around the shared MAC.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : valid/ready. opcode 1 writes coef_value to tap coef_index
//            (indexes at or above TAPS are dropped), opcode 0 filters
//            sample_in. A coefficient write gives no result; a sample gives
//            one transfer on out_ch.
//   out_ch : valid/ready, filtered_out (Q2.14) and gain_now, the gain used
//            for that sample.
//   cfg_*  : write-only thresholds, written while the block is idle.
// Sequence: a sample is accepted in IDLE, then runs every tap through the
//   single shared multiplier (MAC), drains the multiplier pipeline (DRAIN),
//   is scaled by the gain (SCALE) and is loaded into the output register
//   (FINISH); the next item is taken only after that, and after the history
//   push (PUSH) and gain adjust (ADJUST) when the sample closes a peak window.
// Reset clears the delay line, peak history, peak, window count and gain
//   (1.0); coefficients must be written before use.
// A stalled receiver holds the finished result in the output register; a
//   following sample computes and then waits for that register to empty.
// ----------------------------------------------------------------------------
module fir_filter_with_agc_unit #(
	parameter int TAPS           = 32,
	parameter int PEAK_AVG_COUNT = 8,
	parameter int PEAK_WINDOW    = 32
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	fagc_in_if.sink                                 in_ch,
	fagc_out_if.source                              out_ch,
	input  logic                                    cfg_we,
	input  logic [fagc_pkg::CFG_INDEX_W-1:0]        cfg_index,
	input  logic [fagc_pkg::THR_W-1:0]              cfg_data
);
	import fagc_pkg::*;

	localparam int TAP_W = (TAPS > 1) ? $clog2(TAPS) : 1;
	localparam int ACC_W = 32 + $clog2(TAPS);
	localparam int WC_W  = $clog2(PEAK_WINDOW + 1);
	localparam int SUM_W = HIST_W + $clog2(PEAK_AVG_COUNT + 1);
	localparam int CMP_W = SUM_W + 4;

	fagc_state_t state_q, state_d;
	mac_ctrl_t   mac_ctrl;
	mac_stat_t   mac_stat;

	logic                       in_fire;
	logic                       coef_we;
	logic                       out_load;
	logic [TAP_W-1:0]           tap_q;
	logic                       tap_last;
	logic signed [ACC_W-1:0]    acc;
	logic signed [PROD_W-1:0]   prod;
	logic signed [SAMPLE_W-1:0] filt_d;
	logic signed [SAMPLE_W-1:0] filt_q;
	logic signed [SAMPLE_W-1:0] yout;
	logic [PEAK_W-1:0]          mag;
	logic signed [GAIN_W-1:0]   gain_q;
	logic [PEAK_W-1:0]          peak_q;
	logic [WC_W-1:0]            wc_q;
	logic                       window_end;
	logic [HIST_W-1:0]          hist_q [PEAK_AVG_COUNT];
	logic [SUM_W-1:0]           hsum_q;
	logic [THR_W-1:0]           weak_q;
	logic [THR_W-1:0]           high_q;
	logic [THR_W-1:0]           low_q;
	logic [CMP_W-1:0]           avg_x;
	logic [CMP_W-1:0]           weak_lim;
	logic [CMP_W-1:0]           high_lim;
	logic [CMP_W-1:0]           low_lim;
	logic signed [GAIN_W:0]     gain_dn;
	logic signed [GAIN_W:0]     gain_up;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_filt_q;
	logic signed [GAIN_W-1:0]   out_gain_q;

	assign in_fire    = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE);
	assign coef_we    = in_fire && (in_ch.opcode == OP_COEF) &&
	                    ({1'b0, in_ch.coef_index} < (COEF_IDX_W+1)'(TAPS));
	assign tap_last   = (tap_q == TAP_W'(TAPS - 1));
	assign window_end = (wc_q == WC_W'(PEAK_WINDOW - 1));

	fagc_mac #(
		.TAPS (TAPS)
	) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (mac_ctrl),
		.tap_idx   (tap_q),
		.sample    (in_ch.sample_in),
		.coef_we   (coef_we),
		.coef_addr (in_ch.coef_index[TAP_W-1:0]),
		.coef_data (in_ch.coef_value),
		.filt      (filt_q),
		.gain      (gain_q),
		.acc       (acc),
		.prod      (prod),
		.stat      (mac_stat)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weak_q <= WEAK_THRESHOLD_RST;
			high_q <= HIGH_THRESHOLD_RST;
			low_q  <= LOW_THRESHOLD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WEAK_THRESHOLD: weak_q <= cfg_data;
				REG_HIGH_THRESHOLD: high_q <= cfg_data;
				REG_LOW_THRESHOLD:  low_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// next state and MAC commands
	always_comb begin
		state_d  = state_q;
		mac_ctrl = '0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire && (in_ch.opcode == OP_SAMPLE)) begin
					mac_ctrl.shift_in = 1'b1;
					mac_ctrl.clear    = 1'b1;
					state_d           = ST_MAC;
				end
			end
			ST_MAC: begin
				mac_ctrl.step = 1'b1;
				if (tap_last)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!mac_stat.busy)
					state_d = ST_SCALE;
			end
			ST_SCALE: begin
				mac_ctrl.scale = 1'b1;
				state_d        = ST_FINISH;
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ch.ready) begin
					out_load = 1'b1;
					state_d  = window_end ? ST_PUSH : ST_IDLE;
				end
			end
			ST_PUSH:   state_d = ST_ADJUST;
			ST_ADJUST: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// tap counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tap_q <= '0;
		else if (state_q == ST_MAC)
			tap_q <= tap_last ? '0 : tap_q + 1'b1;
	end

	// floor the sum to Q2.14 and saturate
	always_comb begin
		if ((&acc[ACC_W-1:31]) | ~(|acc[ACC_W-1:31]))
			filt_d = acc[31:16];
		else if (acc[ACC_W-1])
			filt_d = OUT_MIN;
		else
			filt_d = OUT_MAX;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DRAIN && !mac_stat.busy)
			filt_q <= filt_d;
	end

	assign yout = sat_scaled(prod);
	assign mag  = abs_sat(yout);

	// average test against thresholds scaled by the history depth
	assign avg_x    = {hsum_q, 4'b0000};
	assign weak_lim = CMP_W'(weak_q) * CMP_W'(PEAK_AVG_COUNT);
	assign high_lim = (CMP_W'(high_q) + 1'b1) * CMP_W'(PEAK_AVG_COUNT);
	assign low_lim  = CMP_W'(low_q) * CMP_W'(PEAK_AVG_COUNT);
	assign gain_dn  = {gain_q[GAIN_W-1], gain_q} - GAIN_STEP;
	assign gain_up  = {gain_q[GAIN_W-1], gain_q} + GAIN_STEP;

	// peak, window, history and gain loop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_ONE;
			peak_q <= '0;
			wc_q   <= '0;
			hsum_q <= '0;
			for (int i = 0; i < PEAK_AVG_COUNT; i++)
				hist_q[i] <= '0;
		end else begin
			unique case (state_q)
				ST_FINISH: begin
					if (out_load) begin
						if (mag > peak_q)
							peak_q <= mag;
						wc_q <= window_end ? '0 : wc_q + 1'b1;
					end
				end
				ST_PUSH: begin
					for (int i = PEAK_AVG_COUNT - 1; i > 0; i--)
						hist_q[i] <= hist_q[i-1];
					hist_q[0] <= peak_q[PEAK_W-1:4];
					hsum_q    <= hsum_q + SUM_W'(peak_q[PEAK_W-1:4]) -
					             SUM_W'(hist_q[PEAK_AVG_COUNT-1]);
					peak_q    <= '0;
				end
				ST_ADJUST: begin
					if (avg_x >= weak_lim) begin
						if (avg_x >= high_lim)
							gain_q <= (gain_dn[GAIN_W] != gain_dn[GAIN_W-1]) ?
							          GAIN_MIN : gain_dn[GAIN_W-1:0];
						else if (avg_x < low_lim)
							gain_q <= (gain_up[GAIN_W] != gain_up[GAIN_W-1]) ?
							          GAIN_MAX : gain_up[GAIN_W-1:0];
					end
				end
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (out_ch.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_filt_q <= yout;
			out_gain_q <= gain_q;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.filtered_out = out_filt_q;
	assign out_ch.gain_now     = out_gain_q;

	// a sample transfer starts the tap pass
	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && (in_ch.opcode == OP_SAMPLE) |=> state_q == ST_MAC)
		else $error("sample transfer did not start the tap pass");

	// the multiplier is free when the gain product is issued
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCALE |-> !mac_stat.busy)
		else $error("gain scaling overlaps tap products");

	// gain moves only in the adjust step
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_ADJUST |=> $stable(gain_q))
		else $error("gain changed outside the adjust step");

	// window count stays inside the window
	assert property (@(posedge clk) disable iff (!arst_n)
		wc_q < WC_W'(PEAK_WINDOW))
		else $error("window count out of range");

	// a pending result is never overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !out_valid_q || out_ch.ready)
		else $error("output register overwritten while full");

endmodule
